FILE: design/sit_pkg.sv
// Shared types, widths and helpers for the segment intersection test block.
package sit_pkg;

  localparam int CW = 24;             // coordinate width
  localparam int DW = CW + 1;         // difference width
  localparam int MW = 2 * DW;         // product of two differences
  localparam int NW = MW + 1;         // sum of two products, signed
  localparam int AW = NW - 1;         // magnitude of num or den
  localparam int QW = DW;             // quotient bits kept
  localparam int PW = AW + DW;        // magnitude of num times delta
  localparam int NCELL = QW;          // divider cells

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] ax1;
    logic signed [CW-1:0] ay1;
    logic signed [CW-1:0] ax2;
    logic signed [CW-1:0] ay2;
    logic signed [CW-1:0] bx1;
    logic signed [CW-1:0] by1;
    logic signed [CW-1:0] bx2;
    logic signed [CW-1:0] by2;
  } coords_t;

  typedef struct packed {
    logic          valid;
    coords_t       c;
    logic          dz;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic [PW-1:0] remx;
    logic [PW-1:0] remy;
    logic [PW-1:0] dsh;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } div_t;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] a);
    return {a[CW-1], a};
  endfunction

endpackage

FILE: design/sit_prep.sv
// Front pipeline: differences, cross products, magnitudes and the wide products.
module sit_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  sit_pkg::coords_t in_c,
  output sit_pkg::div_t   out_d
);
  import sit_pkg::*;

  typedef struct packed {
    logic                 valid;
    coords_t              c;
    logic                 lvl;
    logic signed [MW-1:0] p1, p2, p3, p4;
    logic signed [DW-1:0] ln, ld, dx, dy;
  } s1_t;

  typedef struct packed {
    logic          valid;
    coords_t       c;
    logic          nneg, dneg, dxneg, dyneg, dz;
    logic [AW-1:0] nmag, dmag;
    logic [DW-1:0] dxm, dym;
  } s2_t;

  typedef struct packed {
    logic          valid;
    coords_t       c;
    logic          negx, negy, dz;
    logic [AW-1:0] dmag;
    logic [MW-1:0] xlo, xhi, ylo, yhi;
  } s3_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  div_t s4_r, s4_nxt;

  logic signed [DW-1:0] ayd, axd;
  logic signed [NW-1:0] num, den, nabs, dabs;
  logic [PW-1:0] px, py, dcmp;

  always_comb begin
    ayd = sx(in_c.ay1) - sx(in_c.ay2);
    axd = sx(in_c.ax2) - sx(in_c.ax1);
    s1_nxt.valid = in_valid;
    s1_nxt.c = in_c;
    s1_nxt.lvl = (in_c.ay1 == in_c.ay2);
    s1_nxt.p1 = (sx(in_c.bx1) - sx(in_c.ax1)) * ayd;
    s1_nxt.p2 = (sx(in_c.by1) - sx(in_c.ay1)) * axd;
    s1_nxt.p3 = (sx(in_c.bx1) - sx(in_c.bx2)) * ayd;
    s1_nxt.p4 = (sx(in_c.by1) - sx(in_c.by2)) * axd;
    s1_nxt.ln = sx(in_c.by1) - sx(in_c.ay1);
    s1_nxt.ld = sx(in_c.by1) - sx(in_c.by2);
    s1_nxt.dx = sx(in_c.bx2) - sx(in_c.bx1);
    s1_nxt.dy = sx(in_c.by2) - sx(in_c.by1);
  end

  always_comb begin
    num = s1_r.lvl ? NW'(s1_r.ln) : (NW'(s1_r.p1) + NW'(s1_r.p2));
    den = s1_r.lvl ? NW'(s1_r.ld) : (NW'(s1_r.p3) + NW'(s1_r.p4));
    nabs = num[NW-1] ? -num : num;
    dabs = den[NW-1] ? -den : den;
    s2_nxt.valid = s1_r.valid;
    s2_nxt.c = s1_r.c;
    s2_nxt.nneg = num[NW-1];
    s2_nxt.dneg = den[NW-1];
    s2_nxt.dz = (den == '0);
    s2_nxt.nmag = nabs[AW-1:0];
    s2_nxt.dmag = dabs[AW-1:0];
    s2_nxt.dxneg = s1_r.dx[DW-1];
    s2_nxt.dyneg = s1_r.dy[DW-1];
    s2_nxt.dxm = s1_r.dx[DW-1] ? DW'(-s1_r.dx) : DW'(s1_r.dx);
    s2_nxt.dym = s1_r.dy[DW-1] ? DW'(-s1_r.dy) : DW'(s1_r.dy);
  end

  always_comb begin
    s3_nxt.valid = s2_r.valid;
    s3_nxt.c = s2_r.c;
    s3_nxt.dz = s2_r.dz;
    s3_nxt.dmag = s2_r.dmag;
    s3_nxt.negx = s2_r.nneg ^ s2_r.dxneg ^ s2_r.dneg;
    s3_nxt.negy = s2_r.nneg ^ s2_r.dyneg ^ s2_r.dneg;
    s3_nxt.xlo = s2_r.nmag[DW-1:0] * s2_r.dxm;
    s3_nxt.xhi = s2_r.nmag[AW-1:DW] * s2_r.dxm;
    s3_nxt.ylo = s2_r.nmag[DW-1:0] * s2_r.dym;
    s3_nxt.yhi = s2_r.nmag[AW-1:DW] * s2_r.dym;
  end

  always_comb begin
    px = {s3_r.xhi, {DW{1'b0}}} + PW'(s3_r.xlo);
    py = {s3_r.yhi, {DW{1'b0}}} + PW'(s3_r.ylo);
    dcmp = {s3_r.dmag, {QW{1'b0}}};
    s4_nxt.valid = s3_r.valid;
    s4_nxt.c = s3_r.c;
    s4_nxt.dz = s3_r.dz;
    s4_nxt.negx = s3_r.negx;
    s4_nxt.negy = s3_r.negy;
    // A quotient of 2^QW or more saturates whatever the start point is.
    s4_nxt.ovfx = (px >= dcmp);
    s4_nxt.ovfy = (py >= dcmp);
    s4_nxt.remx = px;
    s4_nxt.remy = py;
    s4_nxt.dsh = {1'b0, s3_r.dmag, {(QW-1){1'b0}}};
    s4_nxt.qx = '0;
    s4_nxt.qy = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign out_d = s4_r;

endmodule

FILE: design/sit_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both axes.
module sit_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  sit_pkg::div_t in_d,
  output sit_pkg::div_t out_d
);
  import sit_pkg::*;

  div_t d_r, d_nxt;
  logic bx, by;

  always_comb begin
    d_nxt = in_d;
    bx = (in_d.remx >= in_d.dsh);
    by = (in_d.remy >= in_d.dsh);
    d_nxt.remx = bx ? in_d.remx - in_d.dsh : in_d.remx;
    d_nxt.remy = by ? in_d.remy - in_d.dsh : in_d.remy;
    d_nxt.qx = {in_d.qx[QW-2:0], bx};
    d_nxt.qy = {in_d.qy[QW-2:0], by};
    d_nxt.dsh = in_d.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_d = d_r;

endmodule

FILE: design/sit_post.sv
// Output stage: offset from B start, saturation, span checks and result register.
module sit_post (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  sit_pkg::div_t   in_d,
  output logic            valid,
  output logic            hit,
  output logic            lines_cross,
  output logic [sit_pkg::CW-1:0] point_x,
  output logic [sit_pkg::CW-1:0] point_y
);
  import sit_pkg::*;

  localparam int SW = CW + 3;

  logic valid_r;
  logic hit_r, hit_nxt, cross_r, cross_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt;

  function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] s,
      input logic [QW-1:0] q, input logic neg, input logic ovf);
    logic signed [SW-1:0] qs, v;
    qs = $signed(SW'(q));
    v = {{3{s[CW-1]}}, s} + (neg ? -qs : qs);
    if (ovf) return neg ? COORD_MIN : COORD_MAX;
    if (v > $signed(SW'(COORD_MAX))) return COORD_MAX;
    if (v < -$signed(SW'(COORD_MAX)) - SW'(1)) return COORD_MIN;
    return v[CW-1:0];
  endfunction

  function automatic logic span(input logic signed [CW-1:0] e1,
      input logic signed [CW-1:0] e2, input logic signed [CW-1:0] v);
    logic signed [CW-1:0] lo, hi;
    lo = (e1 < e2) ? e1 : e2;
    hi = (e1 < e2) ? e2 : e1;
    return (lo <= v) && (v <= hi);
  endfunction

  logic signed [CW-1:0] vx, vy;

  always_comb begin
    vx = place(in_d.c.bx1, in_d.qx, in_d.negx, in_d.ovfx);
    vy = place(in_d.c.by1, in_d.qy, in_d.negy, in_d.ovfy);
    cross_nxt = !in_d.dz;
    px_nxt = in_d.dz ? '0 : vx;
    py_nxt = in_d.dz ? '0 : vy;
    hit_nxt = !in_d.dz && span(in_d.c.ax1, in_d.c.ax2, vx) &&
              span(in_d.c.ay1, in_d.c.ay2, vy) &&
              span(in_d.c.bx1, in_d.c.bx2, vx) &&
              span(in_d.c.by1, in_d.c.by2, vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_d.valid;
      hit_r <= hit_nxt;
      cross_r <= cross_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  assign valid = valid_r;
  assign hit = hit_r;
  assign lines_cross = cross_r;
  assign point_x = px_r;
  assign point_y = py_r;

endmodule

FILE: design/segment_intersection_test_top.sv
// Top level of the two-dimensional segment intersection test.
//
// Each input request carries two segments, A and B, as eight signed Q16.8
// coordinates. Each output request carries the hit flag, the lines-cross flag
// and the crossing point, saturated to the coordinate range and zero when the
// lines are parallel or segment B is degenerate.
// The block is a single pipeline of 30 stages: four front stages build the
// cross products and the wide products, a row of 25 identical divider cells
// resolves one quotient bit per cell for both axes, and a final stage adds
// the offset to B start, saturates and checks both segments' spans.
// A new request is taken every cycle unless the receiver stalls.
// Reset clears every valid flag, so no result appears until a request has
// passed through. When the receiver stalls, the whole pipeline holds and
// in_tready falls in the same cycle; the result register keeps its request.
module segment_intersection_test_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, 24 bits each, from bit 0 up
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit, lines_cross, point_x (24), point_y (24), zero padding, from bit 0 up
  output logic [55:0]  out_tdata
);
  import sit_pkg::*;

  logic en;
  coords_t c;
  div_t chain [NCELL+1];
  logic hit, crossed;
  logic [CW-1:0] px, py;

  // The pipeline moves whenever the result register is empty or being taken.
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  assign c.ax1 = in_tdata[23:0];
  assign c.ay1 = in_tdata[47:24];
  assign c.ax2 = in_tdata[71:48];
  assign c.ay2 = in_tdata[95:72];
  assign c.bx1 = in_tdata[119:96];
  assign c.by1 = in_tdata[143:120];
  assign c.bx2 = in_tdata[167:144];
  assign c.by2 = in_tdata[191:168];

  sit_prep u_prep (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid), .in_c(c), .out_d(chain[0])
  );

  // Cell k resolves quotient bit QW-1-k.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sit_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_d(chain[k]), .out_d(chain[k+1])
    );
  end

  sit_post u_post (
    .clk(clk), .rst_n(rst_n), .en(en), .in_d(chain[NCELL]),
    .valid(out_tvalid), .hit(hit), .lines_cross(crossed),
    .point_x(px), .point_y(py)
  );

  assign out_tdata = {6'b0, py, px, crossed, hit};

endmodule

FILE: test/tb.sv
// Self-checking testbench for the segment intersection test block.
`timescale 1ns / 1ps

module tb;
  import sit_pkg::*;

  localparam int NUM_RANDOM  = 700;
  localparam int LATENCY     = 30;
  localparam int MAX_REPORTS = 10;

  // Expected contents of one output request.
  typedef struct packed {
    logic                 hit;
    logic                 lines_cross;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } crossing_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;

  coords_t   pending_pairs[$];
  crossing_t expected_crossings[$];
  int        mismatch_count;
  bit        stimulus_done;
  int        send_gap;
  int        recv_gap;
  int        hold_off_cycles;

  segment_intersection_test_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Moves start along direction by num/den, truncating towards zero. The
  // quotient is clamped well outside the coordinate range before the add,
  // and the sum is then saturated to the signed coordinate range.
  function automatic logic signed [CW-1:0] step_along(
    input logic signed [63:0]  start,
    input logic signed [63:0]  direction,
    input logic signed [127:0] num,
    input logic signed [127:0] den
  );
    logic signed [127:0] prod;
    logic        [127:0] prod_mag;
    logic        [127:0] den_mag;
    logic        [127:0] quot;
    logic signed [63:0]  offset;
    logic signed [63:0]  sum;
    prod     = num * 128'(direction);
    prod_mag = prod < 0 ? -prod : prod;
    den_mag  = den < 0 ? -den : den;
    quot     = prod_mag / den_mag;
    if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
    offset = 64'(quot);
    sum = ((prod < 0) != (den < 0)) ? start - offset : start + offset;
    if (sum > 64'(COORD_MAX)) sum = 64'(COORD_MAX);
    if (sum < 64'(COORD_MIN)) sum = 64'(COORD_MIN);
    return sum[CW-1:0];
  endfunction

  function automatic bit in_span(input logic signed [63:0] e1, e2, v);
    return (e1 < e2) ? (e1 <= v && v <= e2) : (e2 <= v && v <= e1);
  endfunction

  function automatic crossing_t predict_crossing(input coords_t c);
    crossing_t           r;
    logic signed [63:0]  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, px, py;
    logic signed [127:0] num, den;
    ax1 = 64'(c.ax1); ay1 = 64'(c.ay1); ax2 = 64'(c.ax2); ay2 = 64'(c.ay2);
    bx1 = 64'(c.bx1); by1 = 64'(c.by1); bx2 = 64'(c.bx2); by2 = 64'(c.by2);
    r = '0;
    if (ay1 != ay2) begin
      num = 128'(bx1 - ax1) * 128'(ay1 - ay2) + 128'(by1 - ay1) * 128'(ax2 - ax1);
      den = 128'(bx1 - bx2) * 128'(ay1 - ay2) + 128'(by1 - by2) * 128'(ax2 - ax1);
    end else begin
      num = 128'(by1 - ay1);
      den = 128'(by1 - by2);
    end
    if (den == 0) return r;
    r.lines_cross = 1'b1;
    r.point_x = step_along(bx1, bx2 - bx1, num, den);
    r.point_y = step_along(by1, by2 - by1, num, den);
    px = 64'(r.point_x);
    py = 64'(r.point_y);
    r.hit = in_span(ax1, ax2, px) && in_span(ay1, ay2, py) &&
            in_span(bx1, bx2, px) && in_span(by1, by2, py);
    return r;
  endfunction

  // Fields arrive with ax1 in the lowest bits of the bus.
  function automatic coords_t from_tdata(input logic [191:0] d);
    coords_t c;
    c.ax1 = d[23:0];    c.ay1 = d[47:24];
    c.ax2 = d[71:48];   c.ay2 = d[95:72];
    c.bx1 = d[119:96];  c.by1 = d[143:120];
    c.bx2 = d[167:144]; c.by2 = d[191:168];
    return c;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return COORD_MAX;
    if (roll == 1) return COORD_MIN;
    if (roll < 5) return CW'($signed($urandom_range(0, 4096)) - 2048);
    return CW'($urandom);
  endfunction

  // Builds a pair from two segments, so the directed part reads naturally.
  function automatic coords_t make_pair(input int ax1, ay1, ax2, ay2,
                                        input int bx1, by1, bx2, by2);
    coords_t c;
    c.ax1 = CW'(ax1); c.ay1 = CW'(ay1); c.ax2 = CW'(ax2); c.ay2 = CW'(ay2);
    c.bx1 = CW'(bx1); c.by1 = CW'(by1); c.bx2 = CW'(bx2); c.by2 = CW'(by2);
    return c;
  endfunction

  // Appends a pair to the end of the pending queue.
  task automatic add_pair(input coords_t c);
    pending_pairs.insert(pending_pairs.size(), c);
  endtask

  // Stimulus: a handful of directed pairs, then random ones.
  initial begin
    coords_t c;
    int      mode;
    int      max_c;
    int      min_c;
    max_c = int'(COORD_MAX);
    min_c = int'(COORD_MIN);
    // A plain crossing well inside both segments.
    add_pair(make_pair(0, 0, 2560, 2560, 0, 2560, 2560, 0));
    // Crossing exactly at an end point, which still counts as inside.
    add_pair(make_pair(0, 0, 256, 256, 256, 256, 512, 0));
    // Lines cross beyond the ends of both segments.
    add_pair(make_pair(0, 0, 256, 256, 1024, 0, 2048, -1024));
    // Parallel slanted segments.
    add_pair(make_pair(0, 0, 256, 256, 0, 256, 256, 512));
    // Level A against a vertical and a level B.
    add_pair(make_pair(-512, 100, 512, 100, 0, -512, 0, 512));
    add_pair(make_pair(-512, 100, 512, 100, 0, 300, 700, 300));
    // Degenerate segments: A a single point, B a single point.
    add_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
    add_pair(make_pair(0, 0, 10, 10, 7, 3, 7, 3));
    // A vertical segment with a zero-length x span against a level B.
    add_pair(make_pair(100, -500, 100, 500, -500, 0, 500, 0));
    // Extremes, giving saturation and out-of-range crossings.
    add_pair(make_pair(min_c, min_c, max_c, max_c,
                       min_c, max_c, max_c, min_c));
    add_pair(make_pair(min_c, 0, max_c, 1, max_c, min_c, max_c, max_c));
    add_pair(make_pair(0, 0, 1, 1, max_c, max_c - 1, max_c - 2, max_c));
    add_pair(make_pair(min_c, max_c, max_c, min_c,
                       max_c, max_c, min_c, min_c));
    add_pair(make_pair(0, 0, 3, 1, min_c, min_c, min_c + 1, max_c));
    add_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    add_pair(make_pair(max_c, max_c, max_c, max_c,
                       min_c, min_c, min_c, min_c));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      c.ax1 = rand_coord(); c.ay1 = rand_coord();
      c.ax2 = rand_coord(); c.ay2 = rand_coord();
      c.bx1 = rand_coord(); c.by1 = rand_coord();
      c.bx2 = rand_coord(); c.by2 = rand_coord();
      // Segments around a shared point, so real hits are frequent.
      if (mode < 4) begin
        c.bx1 = c.ax1 + CW'($signed($urandom_range(0, 2000)) - 1000);
        c.ax2 = c.ax1 + CW'($signed($urandom_range(0, 4000)) - 2000);
        c.ay2 = c.ay1 + CW'($signed($urandom_range(0, 4000)) - 2000);
        c.by1 = c.ay1 + CW'($signed($urandom_range(0, 4000)) - 2000);
        c.bx2 = CW'(2 * c.ax1 - c.bx1 + CW'($signed($urandom_range(0, 8)) - 4));
        c.by2 = c.ay1 + c.ay2 - c.by1;
      end else if (mode == 4) begin
        c.ay2 = c.ay1;
      end else if (mode == 5) begin
        c.bx2 = c.bx1 + (c.ax2 - c.ax1);
        c.by2 = c.by1 + (c.ay2 - c.ay1);
      end else if (mode == 6) begin
        c.bx2 = c.bx1;
        c.by2 = c.by1;
      end
      add_pair(c);
    end
    stimulus_done = 1'b1;
  end

  // Driver: offers the next pending pair, with random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else if (in_tvalid && !in_tready) begin
      // Hold the request until it is taken.
    end else begin
      if (in_tvalid) begin
        expected_crossings.push_back(predict_crossing(from_tdata(in_tdata)));
      end
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        // Fields run from ax1 in the low bits, so the packed struct is reversed.
        in_tdata  <= {pending_pairs[0].by2, pending_pairs[0].bx2,
                      pending_pairs[0].by1, pending_pairs[0].bx1,
                      pending_pairs[0].ay2, pending_pairs[0].ax2,
                      pending_pairs[0].ay1, pending_pairs[0].ax1};
        void'(pending_pairs.pop_front());
        in_tvalid <= 1'b1;
        send_gap  <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Cycle count since reset, which times the long hold-off below.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off_cycles <= 0;
    end else begin
      hold_off_cycles <= hold_off_cycles + 1;
    end
  end

  // Receiver back-pressure. Besides random gaps, it holds off once, timed by
  // the counter above, for a long stretch, so the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready      <= 1'b0;
      recv_gap        <= 0;
    end else begin
      if (hold_off_cycles >= 300 && hold_off_cycles < 400) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap   <= pick_gap();
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    crossing_t got;
    crossing_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit         = out_tdata[0];
      got.lines_cross = out_tdata[1];
      got.point_x     = out_tdata[2 +: CW];
      got.point_y     = out_tdata[2 + CW +: CW];
      // A request taken at this same edge is queued by the driver, but a
      // result can never come out in the cycle its request went in.
      if (expected_crossings.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected result: %h", out_tdata);
        end
      end else begin
        want = expected_crossings.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: expected hit %0b cross %0b x %0d y %0d,",
                     want.hit, want.lines_cross, want.point_x, want.point_y,
                     " got hit %0b cross %0b x %0d y %0d",
                     got.hit, got.lines_cross, got.point_x, got.point_y);
          end
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    rst_n          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done);
    while (pending_pairs.size() > 0 || in_tvalid || expected_crossings.size() > 0) begin
      @(posedge clk);
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_crossings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/sit_pkg.sv
design/sit_prep.sv
design/sit_div_cell.sv
design/sit_post.sv
design/segment_intersection_test_top.sv
test/tb.sv
